### hw/rtl/mips_rtype_execute_unit_assert.svh
// Assertion helpers for the R-type execute unit.
`ifndef MIPS_RTYPE_EXECUTE_UNIT_ASSERT_SVH
`define MIPS_RTYPE_EXECUTE_UNIT_ASSERT_SVH

// Clocked check, quiet while reset is asserted
`define MRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset
`define MRE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/mre_pkg.sv
`timescale 1ns / 1ps
package mre_pkg;

  localparam int REG_COUNT = 32;
  localparam int REG_AW = $clog2(REG_COUNT);
  localparam int DATA_W = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Command codes of the input channel
  localparam logic [1:0] CMD_EXEC  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  // Function field codes
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_SYSCALL = 6'h0c;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_SLT     = 6'h2a;

  localparam logic [REG_AW-1:0] SYSCALL_REG = 5'd2;
  localparam logic [DATA_W-1:0] EXIT_CODE = 32'd10;
  localparam logic [DATA_W-1:0] TEXT_BASE_RST = 32'h0040_0000;
  localparam logic [DATA_W-1:0] JR_OFFSET = 32'd4;

  // Register byte address of the configuration port
  localparam logic [2:0] ADDR_TEXT_BASE = 3'd0;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_WRITE,
    OP_READ,
    OP_ADD,
    OP_ADDU,
    OP_SUB,
    OP_AND,
    OP_OR,
    OP_XOR,
    OP_SLT,
    OP_SRL,
    OP_SLL,
    OP_JR,
    OP_SYSCALL,
    OP_BAD
  } op_kind_t;

  // Classified request handed from front to back
  typedef struct packed {
    op_kind_t          kind;
    logic [REG_AW-1:0] src_a;
    logic [REG_AW-1:0] src_b;
    logic [REG_AW-1:0] dst;
    logic [4:0]        shamt;
    logic [DATA_W-1:0] value;
  } op_t;

endpackage

### hw/rtl/mre_front.sv
`timescale 1ns / 1ps
module mre_front
  import mre_pkg::*;
(
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_command,
  input  logic [31:0]       in_instruction,
  input  logic [4:0]        in_reg_index,
  input  logic [31:0]       in_reg_value,
  input  logic              q_full,
  output logic              q_push,
  output op_t               q_op
);

  logic [5:0] funct;

  assign funct = in_instruction[5:0];

  // Accept a request whenever the queue has room
  assign in_stall = q_full;
  assign q_push = in_valid && !q_full;

  // Classify the request and pick its register addresses
  always_comb begin
    q_op.kind  = OP_NOP;
    q_op.src_a = in_instruction[25:21];
    q_op.src_b = in_instruction[20:16];
    q_op.dst   = in_instruction[15:11];
    q_op.shamt = in_instruction[10:6];
    q_op.value = in_reg_value;
    case (in_command)
      CMD_WRITE: begin
        q_op.kind = OP_WRITE;
        q_op.dst  = in_reg_index;
      end
      CMD_READ: begin
        q_op.kind  = OP_READ;
        q_op.src_a = in_reg_index;
      end
      CMD_EXEC: begin
        case (funct)
          FN_ADD:  q_op.kind = OP_ADD;
          FN_ADDU: q_op.kind = OP_ADDU;
          FN_SUB:  q_op.kind = OP_SUB;
          FN_AND:  q_op.kind = OP_AND;
          FN_OR:   q_op.kind = OP_OR;
          FN_XOR:  q_op.kind = OP_XOR;
          FN_SLT:  q_op.kind = OP_SLT;
          FN_SRL:  q_op.kind = OP_SRL;
          FN_SLL:  q_op.kind = OP_SLL;
          FN_JR:   q_op.kind = OP_JR;
          FN_SYSCALL: begin
            q_op.kind  = OP_SYSCALL;
            q_op.src_a = SYSCALL_REG;
          end
          default: q_op.kind = OP_BAD;
        endcase
      end
      default: q_op.kind = OP_NOP;
    endcase
  end

endmodule

### hw/rtl/mre_queue.sv
`timescale 1ns / 1ps
module mre_queue
  import mre_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output op_t  head_op
);

  op_t               entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_op = entry_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Store the pushed request
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

### hw/rtl/mre_back.sv
`timescale 1ns / 1ps
`include "mips_rtype_execute_unit_assert.svh"
module mre_back
  import mre_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  op_t         q_op,
  output logic        q_pop,
  input  logic [31:0] text_base,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_finished,
  output logic        out_jump_valid,
  output logic [31:0] out_jump_index,
  output logic [31:0] out_read_data
);

  // Register file and its per-entry valid bits
  logic [DATA_W-1:0]   mem_r [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;

  // Operand stage
  logic              a_valid_r;
  op_t               a_op_r;
  logic [DATA_W-1:0] mem_a_r, mem_b_r;
  logic              vld_a_r, vld_b_r;
  logic              fwd_a_r, fwd_b_r;
  logic [DATA_W-1:0] fwd_data_r;

  // Output register
  logic              out_valid_r;
  logic [1:0]        status_r;
  logic              fin_r;
  logic              jv_r;
  logic [DATA_W-1:0] ji_r;
  logic [DATA_W-1:0] rdata_r;

  logic              adv, a_ready;
  logic [DATA_W-1:0] opa, opb, sum, diff, jump;
  logic [1:0]        status_nxt;
  logic              fin_nxt, jv_nxt, we;
  logic [DATA_W-1:0] ji_nxt, rdata_nxt, wdata;
  logic              wb_en;

  // Pipeline handshake: output register frees, operand stage refills
  assign adv = !out_valid_r || !out_stall;
  assign a_ready = !a_valid_r || adv;
  assign q_pop = q_valid && a_ready;

  // Operands: bypass the write of the same edge, unwritten entries read zero
  assign opa = fwd_a_r ? fwd_data_r : (vld_a_r ? mem_a_r : '0);
  assign opb = fwd_b_r ? fwd_data_r : (vld_b_r ? mem_b_r : '0);

  assign sum = opa + opb;
  assign diff = opa - opb;
  assign jump = opa - text_base - JR_OFFSET;

  // Execute the request held in the operand stage
  always_comb begin
    status_nxt = ST_OK;
    fin_nxt = 1'b0;
    jv_nxt = 1'b0;
    ji_nxt = '0;
    rdata_nxt = '0;
    we = 1'b0;
    wdata = '0;
    case (a_op_r.kind)
      OP_WRITE: begin
        we = 1'b1;
        wdata = a_op_r.value;
      end
      OP_READ: rdata_nxt = opa;
      OP_ADD: begin
        if (!(opa[DATA_W-1] ^ opb[DATA_W-1]) && (sum[DATA_W-1] ^ opa[DATA_W-1])) begin
          status_nxt = ST_OVF;
        end else begin
          we = 1'b1;
          wdata = sum;
        end
      end
      OP_ADDU: begin
        we = 1'b1;
        wdata = sum;
      end
      OP_SUB: begin
        if ((opa[DATA_W-1] ^ opb[DATA_W-1]) && (diff[DATA_W-1] ^ opa[DATA_W-1])) begin
          status_nxt = ST_OVF;
        end else begin
          we = 1'b1;
          wdata = diff;
        end
      end
      OP_AND: begin
        we = 1'b1;
        wdata = opa & opb;
      end
      OP_OR: begin
        we = 1'b1;
        wdata = opa | opb;
      end
      OP_XOR: begin
        we = 1'b1;
        wdata = opa ^ opb;
      end
      OP_SLT: begin
        we = 1'b1;
        wdata = {{(DATA_W-1){1'b0}}, ($signed(opa) < $signed(opb))};
      end
      OP_SRL: begin
        we = 1'b1;
        wdata = opb >> a_op_r.shamt;
      end
      OP_SLL: begin
        we = 1'b1;
        wdata = opb << a_op_r.shamt;
      end
      OP_SYSCALL: fin_nxt = (opa == EXIT_CODE);
      OP_JR: begin
        jv_nxt = 1'b1;
        ji_nxt = {2'b00, jump[DATA_W-1:2]};
      end
      OP_BAD: status_nxt = ST_BAD;
      default: status_nxt = ST_OK;
    endcase
  end

  // Register zero never takes a write
  assign wb_en = a_valid_r && adv && we && (a_op_r.dst != '0);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      a_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (wb_en) begin
        vld_r[a_op_r.dst] <= 1'b1;
      end
      if (a_ready) begin
        a_valid_r <= q_valid;
      end
      if (adv) begin
        out_valid_r <= a_valid_r;
      end
    end
  end

  // Register file write and registered reads
  always_ff @(posedge clk) begin
    if (wb_en) begin
      mem_r[a_op_r.dst] <= wdata;
    end
    if (q_pop) begin
      mem_a_r <= mem_r[q_op.src_a];
      mem_b_r <= mem_r[q_op.src_b];
    end
  end

  // Load the operand stage with its bypass flags
  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_op_r <= q_op;
      vld_a_r <= vld_r[q_op.src_a];
      vld_b_r <= vld_r[q_op.src_b];
      fwd_a_r <= wb_en && (a_op_r.dst == q_op.src_a);
      fwd_b_r <= wb_en && (a_op_r.dst == q_op.src_b);
      fwd_data_r <= wdata;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (adv && a_valid_r) begin
      status_r <= status_nxt;
      fin_r <= fin_nxt;
      jv_r <= jv_nxt;
      ji_r <= ji_nxt;
      rdata_r <= rdata_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = status_r;
  assign out_finished = fin_r;
  assign out_jump_valid = jv_r;
  assign out_jump_index = ji_r;
  assign out_read_data = rdata_r;

  `MRE_ASSERT(a_no_wb_on_ovf, (a_valid_r && status_nxt != ST_OK) |-> !wb_en, "write on fault")
  `MRE_ASSERT(a_zero_reads_zero, (a_valid_r && a_op_r.kind == OP_READ && a_op_r.src_a == '0) |-> (rdata_nxt == '0), "register zero nonzero")
  `MRE_ASSERT(a_fin_ok, (a_valid_r && fin_nxt) |-> (status_nxt == ST_OK && !jv_nxt), "finished with fault")
  `MRE_ASSERT_ALWAYS(a_reg0_invalid, rst_n |=> !vld_r[0], "register zero marked written")

endmodule

### hw/rtl/mips_rtype_execute_unit.sv
`timescale 1ns / 1ps
// Channel  | Handshake             | Payload
// in       | in_valid / in_stall   | in_command, in_instruction, in_reg_index, in_reg_value
// out      | out_valid / out_stall | out_status, out_finished, out_jump_valid,
//          |                       | out_jump_index, out_read_data
// cfg      | psel / penable/pready | paddr, pwrite, pwdata, prdata
//
// One request per cycle sustained while out_stall stays low; an accepted request passes through
// the queue slot, the operand stage with its registered register file read, and the output register.
// Reset (rst_n low, synchronous) empties the queue and pipeline, zeroes the register file
// through per-entry valid bits and sets text_base to 0x00400000.
// out_stall holds the output register; the pipeline and then the two-entry queue fill,
// and in_stall rises only once the queue is full.
module mips_rtype_execute_unit
  import mre_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_instruction,
  input  logic [4:0]  in_reg_index,
  input  logic [31:0] in_reg_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_finished,
  output logic        out_jump_valid,
  output logic [31:0] out_jump_index,
  output logic [31:0] out_read_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [DATA_W-1:0] text_base_r;
  logic              cfg_sel;
  logic              q_full, q_push, q_pop, q_valid;
  op_t               push_op, head_op;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_sel = ({paddr[2], 2'b00} == ADDR_TEXT_BASE);
  assign prdata = cfg_sel ? text_base_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_base_r <= TEXT_BASE_RST;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      text_base_r <= pwdata;
    end
  end

  mre_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_instruction (in_instruction),
    .in_reg_index   (in_reg_index),
    .in_reg_value   (in_reg_value),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_op           (push_op)
  );

  mre_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (push_op),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_op    (head_op)
  );

  mre_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_op           (head_op),
    .q_pop          (q_pop),
    .text_base      (text_base_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_finished   (out_finished),
    .out_jump_valid (out_jump_valid),
    .out_jump_index (out_jump_index),
    .out_read_data  (out_read_data)
  );

endmodule

### verif/mips_rtype_execute_checker.sv
`timescale 1ns / 1ps
module mips_rtype_execute_checker
  import mre_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_instruction,
  input  logic [4:0]  in_reg_index,
  input  logic [31:0] in_reg_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic        out_finished,
  input  logic        out_jump_valid,
  input  logic [31:0] out_jump_index,
  input  logic [31:0] out_read_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          error_count,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  status;
    logic        finished;
    logic        jump_valid;
    logic [31:0] jump_index;
    logic [31:0] read_data;
  } rtype_result_t;

  // Shadow copy of the architectural state
  logic [31:0] gpr [REG_COUNT];
  logic [31:0] text_base;

  rtype_result_t expected_q [$];
  int taken;
  int returned;

  assign pending = taken - returned;

  // Work out the result of one request and the register write it causes
  function automatic rtype_result_t predict_result(
    input  logic [1:0]  cmd,
    input  logic [31:0] word,
    input  logic [4:0]  idx,
    input  logic [31:0] val,
    output logic        wb_en,
    output logic [4:0]  wb_dst,
    output logic [31:0] wb_val
  );
    rtype_result_t res;
    logic [31:0] a;
    logic [31:0] b;
    logic [4:0]  sh;
    res = '0;
    wb_en = 1'b0;
    wb_dst = idx;
    wb_val = val;
    case (cmd)
      CMD_WRITE: begin
        wb_en = 1'b1;
      end
      CMD_READ: begin
        res.read_data = gpr[idx];
      end
      CMD_EXEC: begin
        a = gpr[word[25:21]];
        b = gpr[word[20:16]];
        sh = word[10:6];
        wb_dst = word[15:11];
        wb_en = 1'b1;
        case (word[5:0])
          FN_ADD: begin
            wb_val = a + b;
            // same-sign operands with a flipped sign in the sum
            if (a[31] == b[31] && wb_val[31] != a[31]) begin
              res.status = ST_OVF;
              wb_en = 1'b0;
            end
          end
          FN_ADDU: wb_val = a + b;
          FN_SUB: begin
            wb_val = a - b;
            // different-sign operands and the difference leaves the sign of rs
            if (a[31] != b[31] && wb_val[31] != a[31]) begin
              res.status = ST_OVF;
              wb_en = 1'b0;
            end
          end
          FN_AND: wb_val = a & b;
          FN_OR:  wb_val = a | b;
          FN_XOR: wb_val = a ^ b;
          FN_SLT: wb_val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
          FN_SRL: wb_val = b >> sh;
          FN_SLL: wb_val = b << sh;
          FN_SYSCALL: begin
            wb_en = 1'b0;
            res.finished = (gpr[SYSCALL_REG] == EXIT_CODE);
          end
          FN_JR: begin
            wb_en = 1'b0;
            res.jump_valid = 1'b1;
            res.jump_index = (a - text_base - JR_OFFSET) >> 2;
          end
          default: begin
            wb_en = 1'b0;
            res.status = ST_BAD;
          end
        endcase
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : model
    rtype_result_t exp_res;
    logic          wb_en;
    logic [4:0]    wb_dst;
    logic [31:0]   wb_val;
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) gpr[i] = '0;
      text_base = TEXT_BASE_RST;
      expected_q.delete();
      error_count = 0;
      taken <= 0;
      returned <= 0;
    end else begin
      // Track register writes and check readback
      if (psel && penable && pready && paddr == ADDR_TEXT_BASE) begin
        if (pwrite) begin
          text_base = pwdata;
        end else if (prdata !== text_base) begin
          $error("text_base readback: expected %h, got %h", text_base, prdata);
          error_count++;
        end
      end

      // Compare a delivered result against the oldest prediction
      if (out_valid && !out_stall) begin
        returned <= returned + 1;
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          exp_res = expected_q.pop_front();
          if (out_status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, out_status);
            error_count++;
          end
          if (out_finished !== exp_res.finished) begin
            $error("finished: expected %0d, got %0d", exp_res.finished, out_finished);
            error_count++;
          end
          if (out_jump_valid !== exp_res.jump_valid) begin
            $error("jump_valid: expected %0d, got %0d", exp_res.jump_valid, out_jump_valid);
            error_count++;
          end
          if (out_jump_index !== exp_res.jump_index) begin
            $error("jump_index: expected %h, got %h", exp_res.jump_index, out_jump_index);
            error_count++;
          end
          if (out_read_data !== exp_res.read_data) begin
            $error("read_data: expected %h, got %h", exp_res.read_data, out_read_data);
            error_count++;
          end
        end
      end

      // Predict each accepted request and apply its writeback
      if (in_valid && !in_stall) begin
        taken <= taken + 1;
        expected_q.push_back(predict_result(in_command, in_instruction, in_reg_index,
                                            in_reg_value, wb_en, wb_dst, wb_val));
        if (wb_en && wb_dst != '0) gpr[wb_dst] = wb_val;
      end
    end
  end

endmodule

### verif/tb_mips_rtype_execute_unit.sv
`timescale 1ns / 1ps
module tb_mips_rtype_execute_unit;
  import mre_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [5:0] FN_UNKNOWN = 6'h3f;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = '0;
  logic [31:0] in_instruction = '0;
  logic [4:0]  in_reg_index = '0;
  logic [31:0] in_reg_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic        out_finished;
  logic        out_jump_valid;
  logic [31:0] out_jump_index;
  logic [31:0] out_read_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int error_count;
  int pending;

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit hold_off_req = 1'b0;

  mips_rtype_execute_unit uut (.*);

  mips_rtype_execute_checker chk (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] rtype_word(input logic [5:0] fn, input logic [4:0] rs,
                                             input logic [4:0] rt, input logic [4:0] rd,
                                             input logic [4:0] sh);
    return {6'd0, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [5:0] pick_funct();
    case ($urandom_range(0, 12))
      0:  return FN_SLL;
      1:  return FN_SRL;
      2:  return FN_JR;
      3:  return FN_SYSCALL;
      4:  return FN_ADD;
      5:  return FN_ADDU;
      6:  return FN_SUB;
      7:  return FN_AND;
      8:  return FN_OR;
      9:  return FN_XOR;
      10: return FN_SLT;
      default: return 6'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'h7fff_ffff;
      3: return 32'h8000_0000;
      4: return 32'hffff_ffff;
      5: return EXIT_CODE;
      default: return $urandom;
    endcase
  endfunction

  // Offer one request, hold it until taken, then maybe go quiet
  task automatic send_request(input logic [1:0] cmd, input logic [31:0] word,
                              input logic [4:0] idx, input logic [31:0] val);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_instruction <= word;
    in_reg_index <= idx;
    in_reg_value <= val;
    do @(posedge clk); while (in_stall);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic send_random_request();
    int          pick;
    logic [1:0]  cmd;
    logic [31:0] word;
    logic [4:0]  idx;
    pick = $urandom_range(0, 99);
    if (pick < 15) cmd = CMD_WRITE;
    else if (pick < 25) cmd = CMD_READ;
    else if (pick < 28) cmd = CMD_UNUSED;
    else cmd = CMD_EXEC;
    word = $urandom;
    word[5:0] = pick_funct();
    idx = 5'($urandom);
    // steer some writes at the syscall register so finished fires
    if (cmd == CMD_WRITE && $urandom_range(0, 7) == 0) idx = SYSCALL_REG;
    send_request(cmd, word, idx, pick_value());
  endtask

  // Single APB transfer to the text_base register, then the bus goes idle
  task automatic cfg_access(input logic is_write, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= ADDR_TEXT_BASE;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic run_phase(input logic [31:0] base, input int count, input bit tx_idle,
                           input bit rx_idle, input bit long_hold);
    drain_results();
    cfg_access(1'b1, base);
    cfg_access(1'b0, '0);
    tx_idle_en = tx_idle;
    rx_idle_en = rx_idle;
    if (long_hold) hold_off_req = 1'b1;
    repeat (count) send_random_request();
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Abort when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_access(1'b0, '0);

    // Directed: register file access, every funct and the corner cases
    send_request(CMD_READ, '0, 5'd5, '0);
    send_request(CMD_WRITE, '0, 5'd0, 32'hffff_ffff);
    send_request(CMD_READ, '0, 5'd0, '0);
    send_request(CMD_WRITE, '0, 5'd1, 32'h7fff_ffff);
    send_request(CMD_WRITE, '0, 5'd2, 32'h8000_0000);
    send_request(CMD_WRITE, '0, 5'd31, 32'hffff_ffff);
    send_request(CMD_WRITE, '0, 5'd4, 32'h0000_0001);
    send_request(CMD_EXEC, rtype_word(FN_ADD, 5'd1, 5'd4, 5'd5, 5'd0), '0, '0);
    send_request(CMD_EXEC, rtype_word(FN_ADD, 5'd31, 5'd4, 5'd6, 5'd0), '0, '0);
    send_request(CMD_EXEC, rtype_word(FN_ADDU, 5'd1, 5'd4, 5'd7, 5'd0), '0, '0);
    send_request(CMD_EXEC, rtype_word(FN_SUB, 5'd2, 5'd4, 5'd8, 5'd0), '0, '0);
    send_request(CMD_EXEC, rtype_word(FN_SUB, 5'd4, 5'd31, 5'd9, 5'd0), '0, '0);
    send_request(CMD_EXEC, rtype_word(FN_AND, 5'd2, 5'd31, 5'd10, 5'd0), '0, '0);
    send_request(CMD_EXEC, rtype_word(FN_OR, 5'd1, 5'd2, 5'd11, 5'd0), '0, '0);
    send_request(CMD_EXEC, rtype_word(FN_XOR, 5'd31, 5'd1, 5'd12, 5'd0), '0, '0);
    send_request(CMD_EXEC, rtype_word(FN_SLT, 5'd2, 5'd1, 5'd13, 5'd0), '0, '0);
    send_request(CMD_EXEC, rtype_word(FN_SLT, 5'd1, 5'd2, 5'd14, 5'd0), '0, '0);
    send_request(CMD_EXEC, rtype_word(FN_SRL, 5'd0, 5'd2, 5'd15, 5'd31), '0, '0);
    send_request(CMD_EXEC, rtype_word(FN_SLL, 5'd0, 5'd4, 5'd16, 5'd31), '0, '0);
    send_request(CMD_EXEC, rtype_word(FN_ADD, 5'd4, 5'd4, 5'd0, 5'd0), '0, '0);
    send_request(CMD_EXEC, rtype_word(FN_JR, 5'd2, 5'd0, 5'd0, 5'd0), '0, '0);
    send_request(CMD_EXEC, rtype_word(FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0), '0, '0);
    send_request(CMD_WRITE, '0, SYSCALL_REG, EXIT_CODE);
    send_request(CMD_EXEC, rtype_word(FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0), '0, '0);
    send_request(CMD_EXEC, rtype_word(FN_UNKNOWN, 5'd1, 5'd2, 5'd3, 5'd0), '0, '0);
    send_request(CMD_UNUSED, 32'hffff_ffff, 5'd31, 32'hffff_ffff);
    send_request(CMD_READ, 32'hffff_ffff, 5'd31, '0);

    // Random phases across text_base settings; the last one runs flat out
    run_phase(32'h0000_0000, 250, 1'b1, 1'b1, 1'b0);
    run_phase(32'hffff_ffff, 200, 1'b0, 1'b1, 1'b1);
    run_phase($urandom, 200, 1'b1, 1'b1, 1'b0);
    run_phase(TEXT_BASE_RST, 100, 1'b0, 1'b0, 1'b0);

    drain_results();
    repeat (8) @(posedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### mips_rtype_execute_unit.f
+incdir+hw/rtl
hw/rtl/mre_pkg.sv
hw/rtl/mre_front.sv
hw/rtl/mre_queue.sv
hw/rtl/mre_back.sv
hw/rtl/mips_rtype_execute_unit.sv
verif/mips_rtype_execute_checker.sv
verif/tb_mips_rtype_execute_unit.sv
